@@ rtl/gbnd_pkg.sv @@
package gbnd_pkg;

    localparam logic [1:0] OP_FEED        = 2'd0;
    localparam logic [1:0] OP_RD_PAYLOAD  = 2'd1;
    localparam logic [1:0] OP_RD_SENTENCE = 2'd2;
    localparam logic [1:0] OP_RD_COUNTER  = 2'd3;

    localparam logic [2:0] EV_NONE       = 3'd0;
    localparam logic [2:0] EV_FRAME_GOOD = 3'd1;
    localparam logic [2:0] EV_CKSUM_ERR  = 3'd2;
    localparam logic [2:0] EV_LEN_ERR    = 3'd3;
    localparam logic [2:0] EV_SENTENCE   = 3'd4;

    localparam int NUM_COUNTERS = 6;
    localparam int CNT_BYTES    = 0;
    localparam int CNT_GOOD     = 1;
    localparam int CNT_CKERR    = 2;
    localparam int CNT_LENERR   = 3;
    localparam int CNT_SENT     = 4;
    localparam int CNT_RESYNC   = 5;

    localparam logic [7:0] SYNC_1      = 8'hB5;
    localparam logic [7:0] SYNC_2      = 8'h62;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] data_byte;
        logic [9:0] read_index;
    } t_req;

    typedef struct packed {
        logic [2:0] event_res;
        logic       resync;
        logic [7:0] msg_class;
        logic [7:0] msg_id;
        logic [9:0] item_length;
    } t_evt;

    typedef struct packed {
        t_evt        evt;
        logic [31:0] read_value;
    } t_rsp;

    typedef enum logic [9:0] {
        M_IDLE    = 10'b00_0000_0001,
        M_SYNC2   = 10'b00_0000_0010,
        M_CLASS   = 10'b00_0000_0100,
        M_ID      = 10'b00_0000_1000,
        M_LENLO   = 10'b00_0001_0000,
        M_LENHI   = 10'b00_0010_0000,
        M_PAYLOAD = 10'b00_0100_0000,
        M_CKA     = 10'b00_1000_0000,
        M_CKB     = 10'b01_0000_0000,
        M_TEXT    = 10'b10_0000_0000
    } t_mode;

endpackage

@@ rtl/gnss_binary_nmea_deframer_unit.sv @@
// Deframer for a mixed binary/text GNSS byte stream with readback of stored data.
// Input channel: i_req_valid / o_req_ready carry one request of type t_req. Opcode
// OP_FEED pushes data_byte into the frame and sentence parser; the read opcodes
// return a stored payload byte, a stored sentence byte or one of six event
// counters in read_value, with 0 for an index beyond the store or counter range.
// Output channel: o_rsp_valid / i_rsp_ready carry exactly one response per
// request, in request order, with the frame or sentence event the byte caused.
// Every request takes two register stages: the first holds the parser result
// and the synchronous read of the payload and sentence memories, the second is
// the output register. A response is presented once its request has passed
// both stages; one request per cycle is sustained while the receiver keeps up.
// When the receiver stalls, the output register holds and one more request is
// still taken into the first stage before o_req_ready drops.
// Reset clears the parser to idle scanning, all counters and both stages. The
// stored payload and sentence bytes are not cleared; read only what was written.
module gnss_binary_nmea_deframer_unit
    import gbnd_pkg::*;
#(
    parameter int PAYLOAD_DEPTH  = 1024,
    parameter int SENTENCE_DEPTH = 128,
    parameter int COUNTER_WIDTH  = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    localparam int PW = $clog2(PAYLOAD_DEPTH);
    localparam int SW = $clog2(SENTENCE_DEPTH);
    localparam logic [1:0] SRC_VAL = 2'd0;
    localparam logic [1:0] SRC_PL  = 2'd1;
    localparam logic [1:0] SRC_ST  = 2'd2;

    logic                     req_acc;
    logic                     s2_free;
    logic                     s1_adv;
    logic                     pl_in_range;
    logic                     st_in_range;
    logic                     pl_re;
    logic                     st_re;
    t_evt                     evt;
    logic [COUNTER_WIDTH-1:0] cnt_value;
    logic                     pl_we;
    logic [PW-1:0]            pl_waddr;
    logic [7:0]               pl_wdata;
    logic [7:0]               pl_rdata;
    logic                     st_we;
    logic [SW-1:0]            st_waddr;
    logic [7:0]               st_wdata;
    logic [7:0]               st_rdata;
    logic [31:0]              s1_read_value;

    logic                     r_s1_valid;
    t_evt                     r_s1_evt;
    logic [1:0]               r_s1_src;
    logic [31:0]              r_s1_value;
    logic                     r_out_valid;
    t_rsp                     r_out;

    assign s2_free     = !r_out_valid || i_rsp_ready;
    assign s1_adv      = r_s1_valid && s2_free;
    assign o_req_ready = !r_s1_valid || s2_free;
    assign req_acc     = i_req_valid && o_req_ready;

    assign pl_in_range = 17'(i_req.read_index) < 17'(PAYLOAD_DEPTH);
    assign st_in_range = 11'(i_req.read_index) < 11'(SENTENCE_DEPTH);
    assign pl_re = req_acc && i_req.opcode == OP_RD_PAYLOAD && pl_in_range;
    assign st_re = req_acc && i_req.opcode == OP_RD_SENTENCE && st_in_range;

    gbnd_parser #(
        .PAYLOAD_DEPTH  (PAYLOAD_DEPTH),
        .SENTENCE_DEPTH (SENTENCE_DEPTH),
        .COUNTER_WIDTH  (COUNTER_WIDTH)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_feed      (req_acc && i_req.opcode == OP_FEED),
        .i_data_byte (i_req.data_byte),
        .i_cnt_sel   (i_req.read_index),
        .o_evt       (evt),
        .o_cnt_value (cnt_value),
        .o_pl_we     (pl_we),
        .o_pl_waddr  (pl_waddr),
        .o_pl_wdata  (pl_wdata),
        .o_st_we     (st_we),
        .o_st_waddr  (st_waddr),
        .o_st_wdata  (st_wdata)
    );

    gbnd_store #(
        .PAYLOAD_DEPTH  (PAYLOAD_DEPTH),
        .SENTENCE_DEPTH (SENTENCE_DEPTH)
    ) u_store (
        .i_clk      (i_clk),
        .i_pl_we    (pl_we),
        .i_pl_waddr (pl_waddr),
        .i_pl_wdata (pl_wdata),
        .i_pl_re    (pl_re),
        .i_pl_raddr (PW'(i_req.read_index)),
        .o_pl_rdata (pl_rdata),
        .i_st_we    (st_we),
        .i_st_waddr (st_waddr),
        .i_st_wdata (st_wdata),
        .i_st_re    (st_re),
        .i_st_raddr (SW'(i_req.read_index)),
        .o_st_rdata (st_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (req_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_s1_evt <= evt;
            if (pl_re) begin
                r_s1_src <= SRC_PL;
            end else if (st_re) begin
                r_s1_src <= SRC_ST;
            end else begin
                r_s1_src <= SRC_VAL;
            end
            if (i_req.opcode == OP_RD_COUNTER) begin
                r_s1_value <= 32'(cnt_value);
            end else begin
                r_s1_value <= '0;
            end
        end
        if (s1_adv) begin
            r_out <= {r_s1_evt, s1_read_value};
        end
    end

    always_comb begin
        case (r_s1_src)
            SRC_PL:  s1_read_value = {24'h000000, pl_rdata};
            SRC_ST:  s1_read_value = {24'h000000, st_rdata};
            default: s1_read_value = r_s1_value;
        endcase
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    a_ready_when_s1_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> o_req_ready)
        else $error("request refused with first stage empty");

    a_event_has_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.evt.event_res != EV_NONE |-> o_rsp.read_value == '0)
        else $error("event response carries read data");

    a_resync_only_on_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_rsp.evt.event_res == EV_FRAME_GOOD
            || o_rsp.evt.event_res == EV_CKSUM_ERR
            || o_rsp.evt.event_res == EV_SENTENCE) |-> !o_rsp.evt.resync)
        else $error("resync flagged on a completed item");

    a_read_has_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc && i_req.opcode != OP_FEED |=>
            r_s1_valid && r_s1_evt.event_res == EV_NONE && !r_s1_evt.resync)
        else $error("read request produced a parser event");

endmodule

@@ rtl/gbnd_store.sv @@
module gbnd_store
    import gbnd_pkg::*;
#(
    parameter int PAYLOAD_DEPTH  = 1024,
    parameter int SENTENCE_DEPTH = 128
) (
    input  logic                              i_clk,
    input  logic                              i_pl_we,
    input  logic [$clog2(PAYLOAD_DEPTH)-1:0]  i_pl_waddr,
    input  logic [7:0]                        i_pl_wdata,
    input  logic                              i_pl_re,
    input  logic [$clog2(PAYLOAD_DEPTH)-1:0]  i_pl_raddr,
    output logic [7:0]                        o_pl_rdata,
    input  logic                              i_st_we,
    input  logic [$clog2(SENTENCE_DEPTH)-1:0] i_st_waddr,
    input  logic [7:0]                        i_st_wdata,
    input  logic                              i_st_re,
    input  logic [$clog2(SENTENCE_DEPTH)-1:0] i_st_raddr,
    output logic [7:0]                        o_st_rdata
);

    logic [7:0] r_pl_mem [PAYLOAD_DEPTH];
    logic [7:0] r_st_mem [SENTENCE_DEPTH];
    logic [7:0] r_pl_rd;
    logic [7:0] r_st_rd;

    always_ff @(posedge i_clk) begin
        if (i_pl_we) begin
            r_pl_mem[i_pl_waddr] <= i_pl_wdata;
        end
        if (i_pl_re) begin
            r_pl_rd <= r_pl_mem[i_pl_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_st_we) begin
            r_st_mem[i_st_waddr] <= i_st_wdata;
        end
        if (i_st_re) begin
            r_st_rd <= r_st_mem[i_st_raddr];
        end
    end

    assign o_pl_rdata = r_pl_rd;
    assign o_st_rdata = r_st_rd;

endmodule

@@ rtl/gbnd_parser.sv @@
module gbnd_parser
    import gbnd_pkg::*;
#(
    parameter int PAYLOAD_DEPTH  = 1024,
    parameter int SENTENCE_DEPTH = 128,
    parameter int COUNTER_WIDTH  = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_feed,
    input  logic [7:0]                        i_data_byte,
    input  logic [9:0]                        i_cnt_sel,
    output t_evt                              o_evt,
    output logic [COUNTER_WIDTH-1:0]          o_cnt_value,
    output logic                              o_pl_we,
    output logic [$clog2(PAYLOAD_DEPTH)-1:0]  o_pl_waddr,
    output logic [7:0]                        o_pl_wdata,
    output logic                              o_st_we,
    output logic [$clog2(SENTENCE_DEPTH)-1:0] o_st_waddr,
    output logic [7:0]                        o_st_wdata
);

    localparam int PW = $clog2(PAYLOAD_DEPTH);
    localparam int SW = $clog2(SENTENCE_DEPTH);
    localparam logic [16:0]   MAX_LEN = 17'(PAYLOAD_DEPTH - 2);
    localparam logic [SW-1:0] ST_LAST = SW'(SENTENCE_DEPTH - 1);

    t_mode                    r_mode, n_mode;
    logic [7:0]               r_sum_a, n_sum_a;
    logic [7:0]               r_sum_b, n_sum_b;
    logic [7:0]               r_class, n_class;
    logic [7:0]               r_id, n_id;
    logic [15:0]              r_len, n_len;
    logic [PW-1:0]            r_pl_cnt, n_pl_cnt;
    logic [7:0]               r_rx_a, n_rx_a;
    logic [SW-1:0]            r_st_cnt, n_st_cnt;
    logic [COUNTER_WIDTH-1:0] r_cnt [NUM_COUNTERS];
    logic [NUM_COUNTERS-1:0]  bump;
    logic [7:0]               fl_a;
    logic [7:0]               fl_b;
    logic [15:0]              full_len;
    logic [PW-1:0]            pl_cnt_inc;

    assign fl_a       = r_sum_a + i_data_byte;
    assign fl_b       = r_sum_b + fl_a;
    assign full_len   = {i_data_byte, r_len[7:0]};
    assign pl_cnt_inc = r_pl_cnt + 1'b1;

    always_comb begin
        n_mode     = r_mode;
        n_sum_a    = r_sum_a;
        n_sum_b    = r_sum_b;
        n_class    = r_class;
        n_id       = r_id;
        n_len      = r_len;
        n_pl_cnt   = r_pl_cnt;
        n_rx_a     = r_rx_a;
        n_st_cnt   = r_st_cnt;
        bump       = '0;
        o_evt      = '0;
        o_pl_we    = 1'b0;
        o_pl_waddr = r_pl_cnt;
        o_pl_wdata = i_data_byte;
        o_st_we    = 1'b0;
        o_st_waddr = r_st_cnt;
        o_st_wdata = i_data_byte;
        if (i_feed) begin
            bump[CNT_BYTES] = 1'b1;
            case (r_mode)
                M_IDLE: begin
                    if (i_data_byte == SYNC_1) begin
                        n_mode = M_SYNC2;
                    end else if (i_data_byte == CHAR_DOLLAR) begin
                        n_st_cnt = '0;
                        n_mode   = M_TEXT;
                    end
                end
                M_SYNC2: begin
                    if (i_data_byte == SYNC_2) begin
                        n_sum_a = '0;
                        n_sum_b = '0;
                        n_mode  = M_CLASS;
                    end else begin
                        bump[CNT_RESYNC] = 1'b1;
                        o_evt.resync     = 1'b1;
                        n_mode = (i_data_byte == SYNC_1) ? M_SYNC2 : M_IDLE;
                    end
                end
                M_CLASS: begin
                    n_class = i_data_byte;
                    n_sum_a = fl_a;
                    n_sum_b = fl_b;
                    n_mode  = M_ID;
                end
                M_ID: begin
                    n_id    = i_data_byte;
                    n_sum_a = fl_a;
                    n_sum_b = fl_b;
                    n_mode  = M_LENLO;
                end
                M_LENLO: begin
                    n_len   = {8'h00, i_data_byte};
                    n_sum_a = fl_a;
                    n_sum_b = fl_b;
                    n_mode  = M_LENHI;
                end
                M_LENHI: begin
                    n_len   = full_len;
                    n_sum_a = fl_a;
                    n_sum_b = fl_b;
                    if ({1'b0, full_len} > MAX_LEN) begin
                        bump[CNT_LENERR]  = 1'b1;
                        bump[CNT_RESYNC]  = 1'b1;
                        o_evt.resync      = 1'b1;
                        o_evt.event_res   = EV_LEN_ERR;
                        o_evt.msg_class   = r_class;
                        o_evt.msg_id      = r_id;
                        n_mode            = M_IDLE;
                    end else begin
                        n_pl_cnt = '0;
                        n_mode   = (full_len == 16'h0000) ? M_CKA : M_PAYLOAD;
                    end
                end
                M_PAYLOAD: begin
                    n_sum_a  = fl_a;
                    n_sum_b  = fl_b;
                    o_pl_we  = 1'b1;
                    n_pl_cnt = pl_cnt_inc;
                    if (16'(pl_cnt_inc) == r_len) begin
                        n_mode = M_CKA;
                    end
                end
                M_CKA: begin
                    n_rx_a = i_data_byte;
                    n_mode = M_CKB;
                end
                M_CKB: begin
                    o_evt.msg_class   = r_class;
                    o_evt.msg_id      = r_id;
                    o_evt.item_length = 10'(r_len);
                    if (r_rx_a == r_sum_a && i_data_byte == r_sum_b) begin
                        bump[CNT_GOOD]  = 1'b1;
                        o_evt.event_res = EV_FRAME_GOOD;
                    end else begin
                        bump[CNT_CKERR] = 1'b1;
                        o_evt.event_res = EV_CKSUM_ERR;
                    end
                    n_mode = M_IDLE;
                end
                M_TEXT: begin
                    if (i_data_byte == CHAR_CR || i_data_byte == CHAR_LF) begin
                        if (r_st_cnt != '0) begin
                            bump[CNT_SENT]    = 1'b1;
                            o_evt.event_res   = EV_SENTENCE;
                            o_evt.item_length = 10'(r_st_cnt);
                        end
                        n_mode = M_IDLE;
                    end else if (i_data_byte == SYNC_1) begin
                        bump[CNT_RESYNC] = 1'b1;
                        o_evt.resync     = 1'b1;
                        n_mode           = M_SYNC2;
                    end else if (r_st_cnt < ST_LAST) begin
                        o_st_we  = 1'b1;
                        n_st_cnt = r_st_cnt + 1'b1;
                    end else begin
                        n_mode = M_IDLE;
                    end
                end
                default: begin
                    n_mode = M_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_pl_cnt <= '0;
            r_st_cnt <= '0;
        end else begin
            r_mode   <= n_mode;
            r_pl_cnt <= n_pl_cnt;
            r_st_cnt <= n_st_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum_a <= n_sum_a;
        r_sum_b <= n_sum_b;
        r_class <= n_class;
        r_id    <= n_id;
        r_len   <= n_len;
        r_rx_a  <= n_rx_a;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_COUNTERS; k++) begin
            if (!i_rst_n) begin
                r_cnt[k] <= '0;
            end else if (bump[k]) begin
                r_cnt[k] <= r_cnt[k] + 1'b1;
            end
        end
    end

    assign o_cnt_value = (i_cnt_sel < 10'(NUM_COUNTERS)) ? r_cnt[3'(i_cnt_sel)] : '0;

endmodule

@@ verif/gbnd_deframe_checker.sv @@
`timescale 1ns / 100ps

module gbnd_deframe_checker
    import gbnd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  logic i_req_ready,
    input  t_req i_req,
    input  logic i_rsp_valid,
    input  logic i_rsp_ready,
    input  t_rsp i_rsp,
    output int   o_errors,
    output int   o_outstanding,
    output int   o_payload_filled,
    output int   o_sentence_filled
);

    localparam int PAYLOAD_SLOTS   = 1024;
    localparam int SENTENCE_SLOTS  = 128;
    localparam int LONGEST_PAYLOAD = PAYLOAD_SLOTS - 2;

    t_mode       mode;
    logic [7:0]  ck_a;
    logic [7:0]  ck_b;
    logic [7:0]  frame_cls;
    logic [7:0]  frame_id;
    logic [7:0]  rx_ck_a;
    logic [15:0] frame_len;
    int          pay_count;
    int          text_count;
    logic [7:0]  pay_mem [PAYLOAD_SLOTS];
    logic [7:0]  text_mem [SENTENCE_SLOTS];
    logic [31:0] counters [NUM_COUNTERS];
    int          pay_filled;
    int          text_filled;
    int          errors = 0;
    t_rsp        pending_rsp [$];

    function void fold(input logic [7:0] b);
        ck_a = ck_a + b;
        ck_b = ck_b + ck_a;
    endfunction

    function void count_event(input int which);
        counters[which[2:0]] = counters[which[2:0]] + 32'd1;
    endfunction

    function automatic t_rsp parse_step(input t_req r);
        t_rsp       o;
        logic [7:0] b;
        o = '0;
        b = r.data_byte;
        case (r.opcode)
            OP_RD_PAYLOAD: begin
                o.read_value = {24'd0, pay_mem[r.read_index]};
            end
            OP_RD_SENTENCE: begin
                if (r.read_index < SENTENCE_SLOTS)
                    o.read_value = {24'd0, text_mem[r.read_index[6:0]]};
            end
            OP_RD_COUNTER: begin
                if (r.read_index < NUM_COUNTERS)
                    o.read_value = counters[r.read_index[2:0]];
            end
            default: begin
                count_event(CNT_BYTES);
                case (mode)
                    M_IDLE: begin
                        if (b == SYNC_1) begin
                            mode = M_SYNC2;
                        end else if (b == CHAR_DOLLAR) begin
                            text_count = 0;
                            mode = M_TEXT;
                        end
                    end
                    M_SYNC2: begin
                        if (b == SYNC_2) begin
                            ck_a = '0;
                            ck_b = '0;
                            mode = M_CLASS;
                        end else begin
                            count_event(CNT_RESYNC);
                            o.evt.resync = 1'b1;
                            mode = (b == SYNC_1) ? M_SYNC2 : M_IDLE;
                        end
                    end
                    M_CLASS: begin
                        frame_cls = b;
                        fold(b);
                        mode = M_ID;
                    end
                    M_ID: begin
                        frame_id = b;
                        fold(b);
                        mode = M_LENLO;
                    end
                    M_LENLO: begin
                        frame_len = {8'd0, b};
                        fold(b);
                        mode = M_LENHI;
                    end
                    M_LENHI: begin
                        frame_len[15:8] = b;
                        fold(b);
                        if (frame_len > LONGEST_PAYLOAD) begin
                            count_event(CNT_LENERR);
                            count_event(CNT_RESYNC);
                            o.evt.resync    = 1'b1;
                            o.evt.event_res = EV_LEN_ERR;
                            o.evt.msg_class = frame_cls;
                            o.evt.msg_id    = frame_id;
                            mode = M_IDLE;
                        end else begin
                            pay_count = 0;
                            mode = (frame_len == 0) ? M_CKA : M_PAYLOAD;
                        end
                    end
                    M_PAYLOAD: begin
                        if (pay_count < frame_len) begin
                            fold(b);
                            pay_mem[pay_count[9:0]] = b;
                            pay_count++;
                            if (pay_count > pay_filled)
                                pay_filled = pay_count;
                        end
                        if (pay_count >= frame_len)
                            mode = M_CKA;
                    end
                    M_CKA: begin
                        rx_ck_a = b;
                        mode = M_CKB;
                    end
                    M_CKB: begin
                        o.evt.msg_class   = frame_cls;
                        o.evt.msg_id      = frame_id;
                        o.evt.item_length = frame_len[9:0];
                        if (rx_ck_a == ck_a && b == ck_b) begin
                            count_event(CNT_GOOD);
                            o.evt.event_res = EV_FRAME_GOOD;
                        end else begin
                            count_event(CNT_CKERR);
                            o.evt.event_res = EV_CKSUM_ERR;
                        end
                        mode = M_IDLE;
                    end
                    M_TEXT: begin
                        if (b == CHAR_CR || b == CHAR_LF) begin
                            if (text_count > 0) begin
                                count_event(CNT_SENT);
                                o.evt.event_res   = EV_SENTENCE;
                                o.evt.item_length = text_count[9:0];
                            end
                            mode = M_IDLE;
                        end else if (b == SYNC_1) begin
                            count_event(CNT_RESYNC);
                            o.evt.resync = 1'b1;
                            mode = M_SYNC2;
                        end else if (text_count < SENTENCE_SLOTS - 1) begin
                            text_mem[text_count[6:0]] = b;
                            text_count++;
                            if (text_count > text_filled)
                                text_filled = text_count;
                        end else begin
                            mode = M_IDLE;
                        end
                    end
                    default: begin
                        mode = M_IDLE;
                    end
                endcase
            end
        endcase
        return o;
    endfunction

    task flag_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t: mismatch in %s, got %0h, expected %0h", $time, what, got, want);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            mode        = M_IDLE;
            ck_a        = '0;
            ck_b        = '0;
            frame_cls   = '0;
            frame_id    = '0;
            rx_ck_a     = '0;
            frame_len   = '0;
            pay_count   = 0;
            text_count  = 0;
            pay_filled  = 0;
            text_filled = 0;
            foreach (counters[k])
                counters[k] = '0;
            pending_rsp.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (pending_rsp.size() == 0) begin
                    flag_mismatch("response without a request", i_rsp.read_value, '0);
                end else begin
                    want = pending_rsp.pop_front();
                    if (i_rsp.evt.event_res !== want.evt.event_res)
                        flag_mismatch("event_res", 32'(i_rsp.evt.event_res),
                                      32'(want.evt.event_res));
                    if (i_rsp.evt.resync !== want.evt.resync)
                        flag_mismatch("resync", 32'(i_rsp.evt.resync),
                                      32'(want.evt.resync));
                    if (i_rsp.evt.msg_class !== want.evt.msg_class)
                        flag_mismatch("msg_class", 32'(i_rsp.evt.msg_class),
                                      32'(want.evt.msg_class));
                    if (i_rsp.evt.msg_id !== want.evt.msg_id)
                        flag_mismatch("msg_id", 32'(i_rsp.evt.msg_id),
                                      32'(want.evt.msg_id));
                    if (i_rsp.evt.item_length !== want.evt.item_length)
                        flag_mismatch("item_length", 32'(i_rsp.evt.item_length),
                                      32'(want.evt.item_length));
                    if (i_rsp.read_value !== want.read_value)
                        flag_mismatch("read_value", i_rsp.read_value, want.read_value);
                end
            end
            if (i_req_valid && i_req_ready)
                pending_rsp.push_back(parse_step(i_req));
        end
        o_errors          <= errors;
        o_outstanding     <= pending_rsp.size();
        o_payload_filled  <= pay_filled;
        o_sentence_filled <= text_filled;
    end

endmodule

@@ verif/tb_gnss_binary_nmea_deframer_unit.sv @@
`timescale 1ns / 100ps

module tb_gnss_binary_nmea_deframer_unit;
    import gbnd_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic i_req_valid;
    logic o_req_ready;
    t_req i_req;
    logic o_rsp_valid;
    logic i_rsp_ready;
    t_rsp o_rsp;

    int errors;
    int outstanding;
    int payload_filled;
    int sentence_filled;
    int sent;
    bit calm;
    bit hold_req;

    gnss_binary_nmea_deframer_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    gbnd_deframe_checker u_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_req_valid       (i_req_valid),
        .i_req_ready       (o_req_ready),
        .i_req             (i_req),
        .i_rsp_valid       (o_rsp_valid),
        .i_rsp_ready       (i_rsp_ready),
        .i_rsp             (o_rsp),
        .o_errors          (errors),
        .o_outstanding     (outstanding),
        .o_payload_filled  (payload_filled),
        .o_sentence_filled (sentence_filled)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    endfunction

    function automatic int sender_gap();
        if (calm || $urandom_range(0, 99) < 70)
            return 0;
        return gap_len();
    endfunction

    function automatic logic [7:0] text_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CHAR_CR || c == CHAR_LF || c == SYNC_1);
        return c;
    endfunction

    task automatic send(input t_req r);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= r;
        @(posedge i_clk);
        while (!o_req_ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic feed(input logic [7:0] b);
        t_req r;
        r.opcode     = OP_FEED;
        r.data_byte  = b;
        r.read_index = 10'($urandom_range(0, 1023));
        send(r);
    endtask

    task automatic read_item(input logic [1:0] op, input int idx);
        t_req r;
        r.opcode     = op;
        r.data_byte  = 8'($urandom_range(0, 255));
        r.read_index = 10'(idx);
        send(r);
    endtask

    task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                              input logic [15:0] len, input bit bad_sum);
        logic [7:0] body [$];
        logic [7:0] ca;
        logic [7:0] cb;
        body.push_back(cls);
        body.push_back(id);
        body.push_back(len[7:0]);
        body.push_back(len[15:8]);
        repeat (len) body.push_back(8'($urandom_range(0, 255)));
        ca = '0;
        cb = '0;
        foreach (body[k]) begin
            ca = ca + body[k];
            cb = cb + ca;
        end
        if (bad_sum) begin
            if ($urandom_range(0, 1))
                ca ^= 8'd1 << $urandom_range(0, 7);
            else
                cb ^= 8'd1 << $urandom_range(0, 7);
        end
        feed(SYNC_1);
        feed(SYNC_2);
        foreach (body[k])
            feed(body[k]);
        feed(ca);
        feed(cb);
    endtask

    task automatic send_overlong(input logic [15:0] len);
        feed(SYNC_1);
        feed(SYNC_2);
        feed(8'($urandom_range(0, 255)));
        feed(8'($urandom_range(0, 255)));
        feed(len[7:0]);
        feed(len[15:8]);
    endtask

    task automatic send_sentence(input int n, input logic [7:0] term);
        feed(CHAR_DOLLAR);
        repeat (n) feed(text_char());
        feed(term);
    endtask

    task automatic random_read();
        int pick;
        pick = $urandom_range(0, 2);
        if (pick == 0 && payload_filled > 0) begin
            read_item(OP_RD_PAYLOAD, $urandom_range(0, payload_filled - 1));
        end else if (pick == 1) begin
            if (sentence_filled > 0 && $urandom_range(0, 1))
                read_item(OP_RD_SENTENCE, $urandom_range(0, sentence_filled - 1));
            else
                read_item(OP_RD_SENTENCE, $urandom_range(128, 1023));
        end else begin
            if ($urandom_range(0, 9) < 8)
                read_item(OP_RD_COUNTER, $urandom_range(0, NUM_COUNTERS - 1));
            else
                read_item(OP_RD_COUNTER, $urandom_range(NUM_COUNTERS, 1023));
        end
    endtask

    function automatic logic [15:0] frame_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return 16'($urandom_range(0, 12));
        if (r < 98)
            return 16'($urandom_range(13, 80));
        return 16'($urandom_range(81, 1022));
    endfunction

    task automatic drain();
        i_req_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (outstanding != 0);
    endtask

    // Response side: random stalls, plus one long hold-off on request.
    initial begin
        int stall_left;
        stall_left = 0;
        i_rsp_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_rsp_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_req   = 1'b0;
                stall_left = 0;
            end else if (stall_left > 0) begin
                i_rsp_ready <= 1'b0;
                stall_left--;
            end else begin
                i_rsp_ready <= 1'b1;
                if (!calm && $urandom_range(0, 99) < 25)
                    stall_left = gap_len();
            end
        end
    end

    initial begin
        int r;
        int k;
        i_rst_n     <= 1'b0;
        i_req_valid <= 1'b0;
        i_req       <= '0;
        calm     = 1'b0;
        hold_req = 1'b0;
        sent     = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        read_item(OP_RD_COUNTER, CNT_BYTES);
        read_item(OP_RD_COUNTER, CNT_RESYNC);
        read_item(OP_RD_COUNTER, NUM_COUNTERS);
        read_item(OP_RD_COUNTER, 1023);
        read_item(OP_RD_SENTENCE, 128);
        read_item(OP_RD_SENTENCE, 1023);
        send_frame(8'hFF, 8'h00, 16'd0, 1'b0);
        send_frame(8'h01, 8'h02, 16'd4, 1'b1);
        feed(SYNC_1);
        feed(8'h41);
        feed(SYNC_1);
        feed(SYNC_1);
        feed(8'h13);
        feed(CHAR_DOLLAR);
        feed(CHAR_CR);
        send_sentence(1, CHAR_LF);
        drain();

        // The longest frame streams in while the response side holds off.
        calm     = 1'b1;
        hold_req = 1'b1;
        send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'd1022, 1'b0);
        calm = 1'b0;
        read_item(OP_RD_PAYLOAD, 1021);
        read_item(OP_RD_PAYLOAD, 0);
        send_overlong(16'd1023);
        send_overlong(16'hFFFF);
        send_sentence(127, CHAR_CR);
        read_item(OP_RD_SENTENCE, 126);
        send_sentence(128, CHAR_LF);
        drain();

        k = 0;
        while (sent < 1400) begin
            if (k % 8 == 0)
                calm = ($urandom_range(0, 5) == 0);
            k++;
            r = $urandom_range(0, 99);
            if (r < 35) begin
                send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           frame_len(), 1'b0);
            end else if (r < 43) begin
                send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           frame_len(), 1'b1);
            end else if (r < 47) begin
                send_overlong(16'($urandom_range(1023, 65535)));
            end else if (r < 62) begin
                send_sentence($urandom_range(0, 20), $urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
            end else if (r < 66) begin
                feed(CHAR_DOLLAR);
                repeat ($urandom_range(0, 6)) feed(text_char());
                send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           frame_len(), 1'b0);
            end else if (r < 70) begin
                feed(SYNC_1);
                feed(8'($urandom_range(0, 255)));
            end else if (r < 74) begin
                feed(SYNC_1);
                feed(SYNC_2);
                repeat ($urandom_range(1, 5)) feed(8'($urandom_range(0, 255)));
            end else if (r < 92) begin
                repeat ($urandom_range(1, 4)) random_read();
            end else begin
                repeat ($urandom_range(1, 6)) feed(8'($urandom_range(0, 255)));
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (errors == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
